FILE: design/amsd_pkg.sv
// Shared types and constants for the moving-sum display encoder.
// No dependencies; every design file but amsd_fifo refers to it by scoped names.
`default_nettype none

package amsd_pkg;

  // Display modes, as written through the configuration port.
  typedef enum logic [1:0] {
    MODE_VOLT = 2'd0,
    MODE_RAW  = 2'd1,
    MODE_BAR  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Digit converter sequence.
  typedef enum logic [2:0] {
    CV_IDLE,
    CV_MUL,
    CV_SUB,
    CV_DIG1,
    CV_DIG2,
    CV_DIG3,
    CV_DONE
  } conv_state_t;

  // Five decimal digits of one window sum plus the mode they are shown in.
  typedef struct packed {
    mode_t      mode;
    logic [4:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
    logic [3:0] d4;
  } digits_t;

  localparam int ADC_W  = 10;   // width of the sample port
  localparam int CHAR_W = 8;
  localparam int POS_W  = 3;
  localparam int DIV_W  = 18;   // covers the largest sum the parameter ranges allow
  localparam int REM_W  = 14;   // holds any value below 10000
  localparam int PROD_W = 37;   // DIV_W x 19-bit reciprocal
  localparam int RECIP_SHIFT = 32;
  // ceil(2^32 / 10000): exact quotient for every DIV_W-bit dividend
  localparam logic [PROD_W-1:0] RECIP_10K = PROD_W'(429497);

  localparam logic [DIV_W-1:0] POW_10K = DIV_W'(10000);
  localparam logic [REM_W-1:0] POW_1K  = REM_W'(1000);
  localparam logic [REM_W-1:0] POW_100 = REM_W'(100);
  localparam logic [REM_W-1:0] POW_10  = REM_W'(10);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_VOLT  = 8'h56;
  localparam logic [CHAR_W-1:0] BAR_FULL = 8'd5;

  localparam logic [POS_W-1:0] LAST_POS_TEXT = 3'd5;
  localparam logic [POS_W-1:0] LAST_POS_BAR  = 3'd7;

endpackage

`default_nettype wire

FILE: design/amsd_front.sv
// Front end: accepts samples, keeps the sample ring and running sum, holds
// the mode register and queues each displayable sum. Uses amsd_pkg.
`default_nettype none

module amsd_front #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 10,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [amsd_pkg::ADC_W-1:0]  adc_sample,
  input  wire logic                        cfg_valid,
  input  wire logic [1:0]                  cfg_data,
  input  wire logic                        q_full,
  output logic                             q_push,
  output logic [SUM_W+1:0]                 q_data
);

  localparam int SLOT_W = $clog2(WINDOW);

  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [WINDOW-1:0]      written;
  logic [SLOT_W-1:0]      write_slot;
  logic [SLOT_W-1:0]      slot_next;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_valid;
  logic [SUM_W-1:0]       window_sum;
  logic [SUM_W-1:0]       window_sum_next;
  amsd_pkg::mode_t        display_mode;

  logic [amsd_pkg::ADC_W+SAMPLE_BITS-1:0] sample_ext;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] oldest;
  logic                   accept;

  assign sample_ext = {{SAMPLE_BITS{1'b0}}, adc_sample};
  assign sample     = sample_ext[SAMPLE_BITS-1:0];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // rd_data is prefetched for the slot about to be overwritten
  assign oldest    = rd_valid ? rd_data : '0;
  assign slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
  assign rd_addr   = accept ? slot_next : write_slot;

  assign window_sum_next = window_sum - SUM_W'(oldest) + SUM_W'(sample);

  assign q_push = accept && (display_mode != amsd_pkg::MODE_NONE);
  assign q_data = {display_mode, window_sum_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= sample;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      write_slot   <= '0;
      rd_valid     <= 1'b0;
      window_sum   <= '0;
      display_mode <= amsd_pkg::MODE_VOLT;
    end else begin
      rd_valid <= written[rd_addr];
      if (accept) begin
        written[write_slot] <= 1'b1;
        write_slot          <= slot_next;
        window_sum          <= window_sum_next;
      end
      if (cfg_valid) begin
        display_mode <= amsd_pkg::mode_t'(cfg_data);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/amsd_fifo.sv
// Two-entry queue between the front end and the digit converter.
// No dependencies.
`default_nettype none

module amsd_fifo #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/amsd_conv.sv
// Digit converter: splits a window sum into five decimal digits, one step
// per cycle until the finished set waits to be taken (reciprocal multiply for the leading digit). Uses amsd_pkg.
`default_nettype none

module amsd_conv #(
  parameter int SUM_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire logic [SUM_W+1:0] q_data,
  output logic                  q_pop,
  output logic                  set_valid,
  output amsd_pkg::digits_t     set_data,
  input  wire logic             set_take
);

  amsd_pkg::conv_state_t state;
  amsd_pkg::conv_state_t state_next;

  logic [amsd_pkg::DIV_W-1:0]  work;
  logic [amsd_pkg::PROD_W-1:0] prod;
  logic [amsd_pkg::REM_W-1:0]  pow;
  logic [3:0]                  dig;
  amsd_pkg::mode_t             mode;
  logic [4:0]                  d0;
  logic [3:0]                  d1;
  logic [3:0]                  d2;
  logic [3:0]                  d3;

  function automatic logic [3:0] digit_of(input logic [amsd_pkg::REM_W-1:0] r,
                                          input logic [amsd_pkg::REM_W-1:0] p);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (r >= amsd_pkg::REM_W'(k) * p) d = 4'(k);
    end
    return d;
  endfunction

  assign prod = amsd_pkg::PROD_W'(work) * amsd_pkg::RECIP_10K;

  always_comb begin
    unique case (state)
      amsd_pkg::CV_DIG1: pow = amsd_pkg::POW_1K;
      amsd_pkg::CV_DIG2: pow = amsd_pkg::POW_100;
      default:           pow = amsd_pkg::POW_10;
    endcase
  end

  assign dig = digit_of(work[amsd_pkg::REM_W-1:0], pow);

  always_comb begin
    unique case (state)
      amsd_pkg::CV_IDLE: state_next = q_empty ? amsd_pkg::CV_IDLE : amsd_pkg::CV_MUL;
      amsd_pkg::CV_MUL:  state_next = amsd_pkg::CV_SUB;
      amsd_pkg::CV_SUB:  state_next = amsd_pkg::CV_DIG1;
      amsd_pkg::CV_DIG1: state_next = amsd_pkg::CV_DIG2;
      amsd_pkg::CV_DIG2: state_next = amsd_pkg::CV_DIG3;
      amsd_pkg::CV_DIG3: state_next = amsd_pkg::CV_DONE;
      amsd_pkg::CV_DONE: begin
        if (!set_take)     state_next = amsd_pkg::CV_DONE;
        else if (!q_empty) state_next = amsd_pkg::CV_MUL;
        else               state_next = amsd_pkg::CV_IDLE;
      end
      default:           state_next = amsd_pkg::CV_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    set_valid = 1'b0;
    unique case (state)
      amsd_pkg::CV_IDLE: q_pop = !q_empty;
      amsd_pkg::CV_DONE: begin
        set_valid = 1'b1;
        q_pop     = set_take && !q_empty;
      end
      default: ;
    endcase
  end

  assign set_data = '{mode: mode, d0: d0, d1: d1, d2: d2, d3: d3, d4: work[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amsd_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= amsd_pkg::DIV_W'(q_data[SUM_W-1:0]);
      mode <= amsd_pkg::mode_t'(q_data[SUM_W+1:SUM_W]);
    end else begin
      unique case (state)
        amsd_pkg::CV_MUL: d0 <= prod[amsd_pkg::RECIP_SHIFT+4:amsd_pkg::RECIP_SHIFT];
        amsd_pkg::CV_SUB: work <= work - amsd_pkg::DIV_W'(d0) * amsd_pkg::POW_10K;
        amsd_pkg::CV_DIG1, amsd_pkg::CV_DIG2, amsd_pkg::CV_DIG3: begin
          work <= work - amsd_pkg::DIV_W'(amsd_pkg::REM_W'(dig) * pow);
          if (state == amsd_pkg::CV_DIG1) d1 <= dig;
          if (state == amsd_pkg::CV_DIG2) d2 <= dig;
          if (state == amsd_pkg::CV_DIG3) d3 <= dig;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/amsd_emit.sv
// Character sequencer: turns one digit set into its run of display
// characters, one beat per cycle while out_ready does not stall it, through an output register. Uses amsd_pkg.
`default_nettype none

module amsd_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          set_valid,
  input  wire amsd_pkg::digits_t             set_data,
  output logic                               set_take,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [amsd_pkg::CHAR_W-1:0]        char_code,
  output logic [amsd_pkg::POS_W-1:0]         position,
  output logic                               last
);

  amsd_pkg::digits_t          cur;
  logic                       active;
  logic [amsd_pkg::POS_W-1:0] k;
  logic                       adv;
  logic                       cur_last;

  function automatic logic [amsd_pkg::CHAR_W-1:0] char_of(input amsd_pkg::digits_t s,
                                                          input logic [2:0] i);
    logic [amsd_pkg::CHAR_W-1:0] c;
    c = '0;
    unique case (s.mode)
      amsd_pkg::MODE_VOLT: begin
        unique case (i)
          3'd0:    c = amsd_pkg::CH_ZERO + 8'(s.d0);
          3'd1:    c = amsd_pkg::CH_ZERO + 8'(s.d1);
          3'd2:    c = amsd_pkg::CH_POINT;
          3'd3:    c = amsd_pkg::CH_ZERO + 8'(s.d2);
          3'd4:    c = amsd_pkg::CH_ZERO + 8'(s.d3);
          default: c = amsd_pkg::CH_VOLT;
        endcase
      end
      amsd_pkg::MODE_RAW: begin
        unique case (i)
          3'd0:    c = amsd_pkg::CH_SPACE;
          3'd1:    c = amsd_pkg::CH_ZERO + 8'(s.d0);
          3'd2:    c = amsd_pkg::CH_ZERO + 8'(s.d1);
          3'd3:    c = amsd_pkg::CH_ZERO + 8'(s.d2);
          3'd4:    c = amsd_pkg::CH_ZERO + 8'(s.d3);
          default: c = amsd_pkg::CH_ZERO + 8'(s.d4);
        endcase
      end
      amsd_pkg::MODE_BAR: begin
        // full thousands = 10*d0 + d1; any nonzero d0 fills all eight cells
        priority if (s.d0 != '0 || {1'b0, i} < s.d1) c = amsd_pkg::BAR_FULL;
        else if ({1'b0, i} == s.d1)                  c = 8'(s.d2[3:1]);
        else                                         c = '0;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  assign cur_last = (k == ((cur.mode == amsd_pkg::MODE_BAR) ? amsd_pkg::LAST_POS_BAR
                                                            : amsd_pkg::LAST_POS_TEXT));
  assign adv      = active && (!out_valid || out_ready);
  assign set_take = set_valid && (!active || (adv && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (set_take) begin
        active <= 1'b1;
        k      <= '0;
      end else if (adv) begin
        k <= k + 1'b1;
        if (cur_last) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      char_code <= char_of(cur, k);
      position  <= k;
      last      <= cur_last;
    end
    if (set_take) begin
      cur <= set_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/adc_moving_sum_display_encoder.sv
// Each accepted sample's sum goes through the two-entry queue, the digit converter
// and the character sequencer's output register. Throughput is bounded by the
// 6-step digit converter and by one character per cycle when out_ready allows.
// A mode-3 sample updates the sum and emits nothing.
// Reset (synchronous, active high) clears control state; ring entries read as
// zero through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module adc_moving_sum_display_encoder #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [amsd_pkg::ADC_W-1:0]    adc_sample,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [amsd_pkg::CHAR_W-1:0]        char_code,
  output logic [amsd_pkg::POS_W-1:0]         position,
  output logic                               last
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [SUM_W+1:0]   q_in;
  logic [SUM_W+1:0]   q_out;
  logic               set_valid;
  logic               set_take;
  amsd_pkg::digits_t  set_data;

  assign cfg_ready = 1'b1;

  amsd_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  amsd_fifo #(
    .WIDTH (SUM_W + 2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  amsd_conv #(
    .SUM_W (SUM_W)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .set_valid (set_valid),
    .set_data  (set_data),
    .set_take  (set_take)
  );

  amsd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set_data  (set_data),
    .set_take  (set_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .position  (position),
    .last      (last)
  );

endmodule

`default_nettype wire

FILE: design/amsd_checker.sv
// Port-level checks on the encoder's output runs, bound to the top level.
// Depends on amsd_pkg and adc_moving_sum_display_encoder.
`default_nettype none

module amsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] char_code,
  input wire logic [2:0] position,
  input wire logic       last
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(position)
                                && $stable(last))
    else $error("output beat changed while stalled");

  // within a run, characters follow back to back at the next position
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && position == $past(position) + 3'd1)
    else $error("run broken or position skipped");

  // runs are six characters of text or eight bar cells
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> position == amsd_pkg::LAST_POS_TEXT
                          || position == amsd_pkg::LAST_POS_BAR)
    else $error("run ended at a bad position");

  // the last cell of a bar run has a code in 0..5
  a_bar_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && position == amsd_pkg::LAST_POS_BAR |-> char_code <= amsd_pkg::BAR_FULL)
    else $error("bar cell code out of range");

endmodule

bind adc_moving_sum_display_encoder amsd_checker u_amsd_checker (.*);

`default_nettype wire

FILE: sim/adc_moving_sum_display_encoder_tb.sv
// Self-checking bench for the moving-sum display encoder: a driver streams
// samples, a monitor predicts each character run and checks it beat by beat.
// Depends on amsd_pkg for the display mode enum and the character constants.
module adc_moving_sum_display_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = 16;
  localparam int SETTLE_TICKS = 20;   // well over the first-character latency
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [amsd_pkg::CHAR_W-1:0] code;
    logic [amsd_pkg::POS_W-1:0]  pos;
    logic                        fin;
  } disp_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [amsd_pkg::ADC_W-1:0] adc_sample = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [amsd_pkg::CHAR_W-1:0] char_code;
  logic [amsd_pkg::POS_W-1:0] position;
  logic last;

  adc_moving_sum_display_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .position   (position),
    .last       (last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow state of the display encoder
  logic [amsd_pkg::ADC_W-1:0] ring_model [RING_DEPTH];
  logic [13:0]     sum_model = '0;
  logic [3:0]      slot_model = '0;
  amsd_pkg::mode_t mode_model = amsd_pkg::MODE_VOLT;

  logic [amsd_pkg::ADC_W-1:0] sample_queue [$];
  disp_char_t                 pending_chars [$];

  bit quiet = 1'b0;          // no gaps and no stalls while set
  int gap_left = 0;
  int stall_left = 0;
  int samples_in = 0;
  int chars_checked = 0;
  int mode_writes = 0;
  int fail_count = 0;
  int level;

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
  end

  function automatic void predict_display_run(input logic [amsd_pkg::ADC_W-1:0] smp);
    int unsigned s;
    int unsigned rem;
    int unsigned dig [5];
    logic [amsd_pkg::CHAR_W-1:0] run [8];
    int cnt;
    bit filled;
    sum_model = sum_model - 14'(ring_model[slot_model]) + 14'(smp);
    ring_model[slot_model] = smp;
    slot_model = slot_model + 4'd1;
    s = sum_model;
    dig[0] = s / 10000;
    s = s % 10000;
    dig[1] = s / 1000;
    s = s % 1000;
    dig[2] = s / 100;
    s = s % 100;
    dig[3] = s / 10;
    dig[4] = s % 10;
    cnt = 0;
    case (mode_model)
      amsd_pkg::MODE_VOLT: begin
        run[0] = amsd_pkg::CHAR_W'(amsd_pkg::CH_ZERO + dig[0]);
        run[1] = amsd_pkg::CHAR_W'(amsd_pkg::CH_ZERO + dig[1]);
        run[2] = amsd_pkg::CH_POINT;
        run[3] = amsd_pkg::CHAR_W'(amsd_pkg::CH_ZERO + dig[2]);
        run[4] = amsd_pkg::CHAR_W'(amsd_pkg::CH_ZERO + dig[3]);
        run[5] = amsd_pkg::CH_VOLT;
        cnt = 6;
      end
      amsd_pkg::MODE_RAW: begin
        run[0] = amsd_pkg::CH_SPACE;
        for (int k = 0; k < 5; k++)
          run[k+1] = amsd_pkg::CHAR_W'(amsd_pkg::CH_ZERO + dig[k]);
        cnt = 6;
      end
      amsd_pkg::MODE_BAR: begin
        rem = sum_model;
        filled = 1'b0;
        for (int k = 0; k < 8; k++) begin
          if (filled) begin
            run[k] = '0;
          end else if (rem >= 1000) begin
            run[k] = amsd_pkg::BAR_FULL;
            rem = rem - 1000;
          end else begin
            run[k] = amsd_pkg::CHAR_W'(rem / 200);
            filled = 1'b1;
          end
        end
        cnt = 8;
      end
      default: cnt = 0;   // unused mode: ring moves, nothing shown
    endcase
    for (int k = 0; k < cnt; k++)
      pending_chars.push_back('{code: run[k], pos: amsd_pkg::POS_W'(k),
                                fin: (k == cnt - 1)});
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sample_queue.size() != 0) begin
        in_valid <= 1'b1;
        adc_sample <= sample_queue.pop_front();
        gap_left = quiet ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks mode writes and accepted samples, checks each character beat, drives out_ready
  always @(posedge clk) begin
    disp_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_model = amsd_pkg::mode_t'(cfg_data);
        mode_writes++;
      end
      if (in_valid && in_ready) begin
        predict_display_run(adc_sample);
        samples_in++;
      end
      if (out_valid && out_ready) begin
        if (pending_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected beat: code %0h pos %0d last %0b", char_code, position, last);
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (char_code !== want.code || position !== want.pos || last !== want.fin) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("mismatch: expected code %0h pos %0d last %0b, got %0h %0d %0b",
                       want.code, want.pos, want.fin, char_code, position, last);
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Wait until every sample is taken and every character is back, then let
  // a mode-3 sample still in flight finish before anything else happens.
  task automatic wait_idle();
    @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic set_mode(input amsd_pkg::mode_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic feed(input int unsigned v, input int n);
    repeat (n) sample_queue.push_back(amsd_pkg::ADC_W'(v));
  endtask

  initial begin
    amsd_pkg::mode_t order [4];
    amsd_pkg::mode_t m;
    int r;
    order = '{amsd_pkg::MODE_BAR, amsd_pkg::MODE_VOLT, amsd_pkg::MODE_NONE,
              amsd_pkg::MODE_RAW};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset mode first, then each mode while the sum climbs to full scale
    feed(0, 1);
    feed(1023, 1);
    feed(1, 1);
    feed(512, 1);
    wait_idle();
    set_mode(amsd_pkg::MODE_BAR);
    feed(1023, 4);
    wait_idle();
    set_mode(amsd_pkg::MODE_NONE);
    feed(1023, 6);
    wait_idle();
    set_mode(amsd_pkg::MODE_RAW);
    feed(1023, 4);
    wait_idle();
    set_mode(amsd_pkg::MODE_VOLT);
    feed(1023, 3);     // ring now all 1023: largest sum
    wait_idle();

    // Random phases, each one mode; one phase without gaps or stalls
    for (int ph = 0; ph < 8; ph++) begin
      m = (ph < 4) ? order[ph] : amsd_pkg::mode_t'($urandom_range(0, 3));
      set_mode(m);
      quiet = (ph == 5);
      level = $urandom_range(0, 1023);
      for (int i = 0; i < 29; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25) feed(1023, 1);
        else if (r < 35) feed(0, 1);
        else if (r < 60) feed((level + $urandom_range(0, 15)) % 1024, 1);
        else feed($urandom_range(0, 1023), 1);
      end
      wait_idle();
      quiet = 1'b0;
    end

    if (pending_chars.size() != 0) begin
      fail_count += pending_chars.size();
      $display("%0d characters never arrived", pending_chars.size());
    end
    $display("run covered %0d samples and %0d character beats over %0d mode writes",
             samples_in, chars_checked, mode_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule
